// ===== rtl/snx3_pkg.sv =====
// Shared types, constants and the divide-by-three helper for the simplex noise core.
package snx3_pkg;

    typedef logic signed [19:0] t_off;   // corner offset, Q16 fraction bits
    typedef logic        [16:0] t_lat;   // lattice coordinate, low bits only

    localparam int NUM_STG = 13;

    localparam logic signed [41:0] C_SIX_TENTHS = 42'sd2576980378;
    localparam logic signed [41:0] C_ONE_Q16    = 42'sd65536;
    localparam t_off C_G3     = 20'sd10923;
    localparam t_off C_TWO_G3 = 20'sd21845;
    localparam t_off C_HALF   = 20'sd32768;
    localparam t_off C_ONE    = 20'sd65536;

    // floor(w / 3) for w below 2^22 by reciprocal multiply
    function automatic logic [21:0] snx3_div3(input logic [21:0] w);
        logic [45:0] p;
        p = {24'b0, w} * 46'd5592406;
        return p[45:24];
    endfunction

endpackage

// ===== rtl/snx3_skew.sv =====
// Skew and unskew pipeline: cell origin and offset of the first corner.
module snx3_skew import snx3_pkg::*; (
    input  logic               i_clk,
    input  logic [5:0]         i_ld,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    output t_off               o_x0,
    output t_off               o_y0,
    output t_off               o_z0,
    output t_lat               o_i,
    output t_lat               o_j,
    output t_lat               o_k
);

    logic signed [31:0] r0_c [3];
    logic [16:0]        r0_hi;
    logic [18:0]        r0_w;
    logic signed [31:0] r1_c [3];
    logic [31:0]        r1_s;
    logic [16:0]        r2_l [3];
    logic [15:0]        r2_f [3];
    logic [31:0]        r2_s;
    logic [16:0]        r3_l [3];
    logic [15:0]        r3_f [3];
    logic [31:0]        r3_s;
    logic [18:0]        r3_ijk;
    logic [21:0]        r3_w;
    logic [16:0]        r4_l [3];
    logic [15:0]        r4_f [3];
    logic [19:0]        r4_d;
    logic [19:0]        r5_o [3];
    logic [16:0]        r5_l [3];

    logic signed [34:0] n_sum;
    logic [33:0]        n_u;
    logic [32:0]        n_p;
    logic [31:0]        n_q;
    logic [32:0]        n_xs [3];
    logic [18:0]        n_ijk;
    logic [19:0]        n_m;
    logic [21:0]        n_dv;
    logic [19:0]        n_t;

    always_comb begin
        n_sum = 35'(i_x) + 35'(i_y) + 35'(i_z) + 35'sd6442450944;
        n_u   = n_sum[33:0];
        n_p   = {16'b0, r0_hi} * 33'd43690;
        n_q   = n_p[31:0] + {10'b0, snx3_div3({3'b0, r0_w})};
        for (int a = 0; a < 3; a++) begin
            n_xs[a] = {r1_c[a][31], r1_c[a]} + {r1_s[31], r1_s};
        end
        n_ijk = {{2{r2_l[0][16]}}, r2_l[0]} + {{2{r2_l[1][16]}}, r2_l[1]}
              + {{2{r2_l[2][16]}}, r2_l[2]};
        n_m   = {r3_ijk[18], r3_ijk} * 20'd10922;
        n_dv  = snx3_div3(r3_w);
        n_t   = n_m + n_dv[19:0] - 20'h80000;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r0_c[0] <= i_x;
            r0_c[1] <= i_y;
            r0_c[2] <= i_z;
            r0_hi   <= n_u[33:17];
            r0_w    <= {1'b0, n_u[33:17], 1'b0} + {2'b0, n_u[16:0]};
        end
        if (i_ld[1]) begin
            r1_c <= r0_c;
            r1_s <= {~n_q[31], n_q[30:0]};
        end
        if (i_ld[2]) begin
            for (int a = 0; a < 3; a++) begin
                r2_l[a] <= n_xs[a][32:16];
                r2_f[a] <= n_xs[a][15:0];
            end
            r2_s <= r1_s;
        end
        if (i_ld[3]) begin
            r3_l   <= r2_l;
            r3_f   <= r2_f;
            r3_s   <= r2_s;
            r3_ijk <= n_ijk;
            r3_w   <= {{2{n_ijk[18]}}, n_ijk, 1'b0} + 22'd1572864;
        end
        if (i_ld[4]) begin
            r4_l <= r3_l;
            r4_f <= r3_f;
            r4_d <= n_t - r3_s[19:0];
        end
        if (i_ld[5]) begin
            r5_l <= r4_l;
            for (int a = 0; a < 3; a++) begin
                r5_o[a] <= {4'b0, r4_f[a]} + r4_d;
            end
        end
    end

    assign o_x0 = r5_o[0];
    assign o_y0 = r5_o[1];
    assign o_z0 = r5_o[2];
    assign o_i  = r5_l[0];
    assign o_j  = r5_l[1];
    assign o_k  = r5_l[2];

endmodule

// ===== rtl/snx3_corner.sv =====
// One simplex corner: falloff, lattice hash, gradient and weighted contribution.
module snx3_corner import snx3_pkg::*; (
    input  logic               i_clk,
    input  logic [4:0]         i_ld,
    input  logic [31:0]        i_seed,
    input  t_off               i_dx,
    input  t_off               i_dy,
    input  t_off               i_dz,
    input  t_lat               i_ci,
    input  t_lat               i_cj,
    input  t_lat               i_ck,
    output logic signed [37:0] o_prod
);

    t_off               r_d [4][3];
    logic [38:0]        ra_sq [3];
    logic [16:0]        ra_a;
    logic [15:0]        rb_t;
    logic               rb_pos;
    logic [16:0]        rb_a;
    logic [16:0]        rb_a2;
    logic [15:0]        rc_t2;
    logic               rc_pos;
    logic [16:0]        rc_a3;
    logic [15:0]        rd_t4;
    logic               rd_pos;
    logic [16:0]        rd_a4;
    logic signed [37:0] re_prod;

    logic signed [39:0] n_sq [3];
    logic signed [41:0] n_diff;
    logic [31:0]        n_tt2;
    logic [31:0]        n_tt4;
    logic [3:0]         n_h;
    t_off               n_u;
    t_off               n_v;
    logic signed [20:0] n_g;

    always_comb begin
        n_sq[0] = i_dx * i_dx;
        n_sq[1] = i_dy * i_dy;
        n_sq[2] = i_dz * i_dz;
        n_diff  = C_SIX_TENTHS - $signed({3'b0, ra_sq[0]}) - $signed({3'b0, ra_sq[1]})
                - $signed({3'b0, ra_sq[2]});
        n_tt2   = {16'b0, rb_t} * {16'b0, rb_t};
        n_tt4   = {16'b0, rc_t2} * {16'b0, rc_t2};
        n_h     = rd_a4[3:0] ^ rd_a4[16:13];
        n_u     = n_h[3] ? r_d[3][1] : r_d[3][0];
        if (n_h[3:2] == 2'b00) begin
            n_v = r_d[3][1];
        end else if (n_h == 4'd12 || n_h == 4'd14) begin
            n_v = r_d[3][0];
        end else begin
            n_v = r_d[3][2];
        end
        n_g = (n_h[0] ? -21'(n_u) : 21'(n_u)) + (n_h[1] ? -21'(n_v) : 21'(n_v));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_d[0][0] <= i_dx;
            r_d[0][1] <= i_dy;
            r_d[0][2] <= i_dz;
            for (int a = 0; a < 3; a++) begin
                ra_sq[a] <= n_sq[a][38:0];
            end
            ra_a <= i_seed[16:0] + i_ci * 17'd1619 + i_cj * 17'd31337 + i_ck * 17'd6971;
        end
        if (i_ld[1]) begin
            r_d[1] <= r_d[0];
            rb_t   <= n_diff[31:16];
            rb_pos <= n_diff >= C_ONE_Q16;
            rb_a   <= ra_a;
            rb_a2  <= ra_a * ra_a;
        end
        if (i_ld[2]) begin
            r_d[2] <= r_d[1];
            rc_t2  <= n_tt2[31:16];
            rc_pos <= rb_pos;
            rc_a3  <= rb_a2 * rb_a;
        end
        if (i_ld[3]) begin
            r_d[3] <= r_d[2];
            rd_t4  <= n_tt4[31:16];
            rd_pos <= rc_pos;
            rd_a4  <= rc_a3 * 17'd60493;
        end
        if (i_ld[4]) begin
            // drop corners whose falloff is not positive
            re_prod <= rd_pos ? $signed({1'b0, rd_t4}) * n_g : 38'sd0;
        end
    end

    assign o_prod = re_prod;

endmodule

// ===== rtl/simplex_noise_3d_core.sv =====
// Top level of the 3D simplex noise core: handshake, corner ordering and final sum.
//
//   Channel   Direction  Handshake           Payload
//   -------   ---------  ------------------  ----------------------------------
//   point     in         i_valid / o_stall   i_coord_x, i_coord_y, i_coord_z
//   noise     out        o_valid / i_stall   o_noise_value
//   config    in         i_cfg_we            i_cfg_data (noise seed)
//
// Throughput is one item per cycle unless i_stall holds the output; the 13 register
// stages are six for skew and unskew, one for corner ordering, five for falloff
// and hash, one for the sum and clamp. Reset clears the valid bits and the seed.
// Each stage holds while the next one is full and held, so a stall at the output
// fills bubbles first and only then raises o_stall; no item is lost or repeated.
module simplex_noise_3d_core import snx3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_noise_value,
    input  logic               i_cfg_we,
    input  logic signed [31:0] i_cfg_data
);

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] ld;
    logic [31:0]        r_seed;

    t_off x0, y0, z0;
    t_lat ci, cj, ck;

    // corner offsets and lattice coordinates after ordering
    t_off               r_d [4][3];
    t_lat               r_c [4][3];
    logic signed [37:0] prod [4];
    logic signed [17:0] r_out;

    logic [2:0]         n_o1;
    logic [2:0]         n_o2;
    t_off               n_p [3];
    t_lat               n_l [3];
    logic signed [39:0] n_sum;
    logic signed [28:0] n_n;

    // a stage loads when it is empty or some later stage frees a slot
    always_comb begin
        for (int s = 0; s < NUM_STG; s++) begin
            ld[s] = !i_stall || ((r_vld | ((NUM_STG'(1) << s) - NUM_STG'(1))) != '1);
        end
    end

    assign o_stall = !ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_seed <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            if (ld[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NUM_STG; s++) begin
                if (ld[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    snx3_skew u_skew (
        .i_clk (i_clk),
        .i_ld  (ld[5:0]),
        .i_x   (i_coord_x),
        .i_y   (i_coord_y),
        .i_z   (i_coord_z),
        .o_x0  (x0),
        .o_y0  (y0),
        .o_z0  (z0),
        .o_i   (ci),
        .o_j   (cj),
        .o_k   (ck)
    );

    // pick the second and third corner steps from the order of the offsets
    always_comb begin
        if (x0 >= y0) begin
            if (y0 >= z0) begin
                n_o1 = 3'b001; n_o2 = 3'b011;
            end else if (x0 >= z0) begin
                n_o1 = 3'b001; n_o2 = 3'b101;
            end else begin
                n_o1 = 3'b100; n_o2 = 3'b101;
            end
        end else begin
            if (y0 < z0) begin
                n_o1 = 3'b100; n_o2 = 3'b110;
            end else if (x0 < z0) begin
                n_o1 = 3'b010; n_o2 = 3'b110;
            end else begin
                n_o1 = 3'b010; n_o2 = 3'b011;
            end
        end
        n_p[0] = x0;
        n_p[1] = y0;
        n_p[2] = z0;
        n_l[0] = ci;
        n_l[1] = cj;
        n_l[2] = ck;
    end

    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            for (int a = 0; a < 3; a++) begin
                r_d[0][a] <= n_p[a];
                r_c[0][a] <= n_l[a];
                r_d[1][a] <= n_p[a] + C_G3 - (n_o1[a] ? C_ONE : '0);
                r_c[1][a] <= n_l[a] + t_lat'(n_o1[a]);
                r_d[2][a] <= n_p[a] + C_TWO_G3 - (n_o2[a] ? C_ONE : '0);
                r_c[2][a] <= n_l[a] + t_lat'(n_o2[a]);
                r_d[3][a] <= n_p[a] - C_HALF;
                r_c[3][a] <= n_l[a] + t_lat'(1);
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_corner
        snx3_corner u_corner (
            .i_clk  (i_clk),
            .i_ld   (ld[11:7]),
            .i_seed (r_seed),
            .i_dx   (r_d[g][0]),
            .i_dy   (r_d[g][1]),
            .i_dz   (r_d[g][2]),
            .i_ci   (r_c[g][0]),
            .i_cj   (r_c[g][1]),
            .i_ck   (r_c[g][2]),
            .o_prod (prod[g])
        );
    end

    // add the corners, scale by 32 into Q16, clamp to [-1, 1]
    always_comb begin
        n_sum = 40'(prod[0]) + 40'(prod[1]) + 40'(prod[2]) + 40'(prod[3]);
        n_n   = n_sum[39:11];
    end

    always_ff @(posedge i_clk) begin
        if (ld[12]) begin
            if (n_n > 29'sd65536) begin
                r_out <= 18'sd65536;
            end else if (n_n < -29'sd65536) begin
                r_out <= -18'sd65536;
            end else begin
                r_out <= n_n[17:0];
            end
        end
    end

    assign o_valid       = r_vld[NUM_STG-1];
    assign o_noise_value = r_out;

endmodule

// ===== rtl/snx3_checker.sv =====
// Port-level checks for the simplex noise core, bound to the top level.
module snx3_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [31:0] i_coord_x,
    input logic signed [31:0] i_coord_y,
    input logic signed [31:0] i_coord_z,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [17:0] o_noise_value,
    input logic               i_cfg_we,
    input logic signed [31:0] i_cfg_data
);

    // result always lies within the clamp range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_noise_value <= 18'sd65536 && o_noise_value >= -18'sd65536))
        else $error("noise value outside [-1, 1]");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_noise_value)))
        else $error("stalled result changed");

    // the input stalls only when a finished item waits at the output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind simplex_noise_3d_core snx3_checker u_snx3_checker (.*);
